// ===== sv/rxm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rxm_pkg;
    localparam int QFRAC = 24;
    localparam logic signed [31:0] QONE = 32'sd16777216;
    localparam logic signed [31:0] SMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SMIN = 32'sh80000000;
    localparam logic [30:0] MIN_DET_RESET = 31'd16777;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_P = 2'd1;
    localparam logic [1:0] ST_BAD_M = 2'd2;

    typedef struct packed {
        logic [15:0] rx, ry, gx, gy, bx, by, wx, wy;
    } chroma_t;

    typedef struct packed {
        chroma_t    c;
        logic       zero_y;
    } job_t;

    // Saturate a wide signed value into Q8.24.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'sh7FFFFFFF) r = SMAX;
            else if (v < -66'sh80000000) r = SMIN;
            else r = v[31:0];
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== sv/rxm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider: round((|a| << 24) / |b|) with sign, saturated. One quotient
// bit per cycle.
module rxm_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic                    done,
    output logic signed [31:0]      q
);
    import rxm_pkg::*;

    logic [56:0] num_reg, num_next;
    logic [57:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [56:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, neg_reg, neg_next, done_reg, done_next;
    logic [57:0] sh;
    logic [31:0] ma, mb;
    logic [56:0] na;
    logic signed [65:0] sq;

    assign ma = a[31] ? 32'(-a) : 32'(a);
    assign mb = b[31] ? 32'(-b) : 32'(b);
    // Add half the divisor before dividing to get round half away from zero.
    assign na = {1'b0, ma, 24'd0} + 57'(mb >> 1);
    assign sh = {rem_reg[56:0], num_reg[56]};
    assign sq = neg_reg ? -$signed({9'd0, quo_reg}) : $signed({9'd0, quo_reg});

    always_comb begin
        num_next = num_reg; rem_next = rem_reg; den_next = den_reg;
        quo_next = quo_reg; cnt_next = cnt_reg; busy_next = busy_reg;
        neg_next = neg_reg; done_next = 1'b0;
        if (start) begin
            num_next = na; rem_next = '0; den_next = mb; quo_next = '0;
            cnt_next = 6'd57; busy_next = 1'b1; neg_next = a[31] ^ b[31];
        end else if (busy_reg) begin
            num_next = {num_reg[55:0], 1'b0};
            if (sh >= {26'd0, den_reg}) begin
                rem_next = sh - {26'd0, den_reg};
                quo_next = {quo_reg[55:0], 1'b1};
            end else begin
                rem_next = sh;
                quo_next = {quo_reg[55:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next; rem_reg <= rem_next; den_reg <= den_next;
        quo_reg <= quo_next; cnt_reg <= cnt_next; neg_reg <= neg_next;
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign q = sat32(sq);
endmodule
`default_nettype wire

// ===== sv/rxm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Accepts items, flags zero y, and pushes into a two-entry queue.
module rxm_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rxm_pkg::chroma_t in_c,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output rxm_pkg::job_t         q_job
);
    import rxm_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    job_t       j;

    assign j.c = in_c;
    assign j.zero_y = (in_c.ry == 16'd0) || (in_c.gy == 16'd0) ||
                      (in_c.by == 16'd0) || (in_c.wy == 16'd0);
    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_job = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= j;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !q_valid) else $error("empty valid");
endmodule
`default_nettype wire

// ===== sv/rxm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: works through a register file one entry at a time, with one shared divider.
module rxm_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [30:0]   min_det,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire rxm_pkg::job_t q_job,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_which,
    output logic [1:0]         m_row,
    output logic [1:0]         m_col,
    output logic signed [31:0] m_val,
    output logic [1:0]         m_status,
    output logic               m_last
);
    import rxm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_COL, S_COLW, S_INV, S_DET, S_IDIV, S_IDIVW, S_WT, S_MM, S_EMIT
    } state_t;

    state_t state_reg;
    logic signed [31:0] p_reg [9];   // matrix being inverted / P
    logic signed [31:0] pp_reg [9];  // saved P
    logic signed [31:0] cof_reg [9];
    logic signed [31:0] inv_reg [9];
    logic signed [31:0] m_reg [9];
    logic signed [31:0] wh_reg [3];
    logic signed [31:0] w_reg [3];
    logic signed [31:0] det_reg;
    logic [4:0] k_reg;
    logic       pass_reg;  // 0 inverting P, 1 inverting M
    chroma_t    c_reg;
    logic       ov_reg, ow_reg, ol_reg;
    logic [1:0] orow_reg, ocol_reg, ost_reg;
    logic signed [31:0] oval_reg;

    logic        dstart, ddone;
    logic signed [31:0] da, db, dq;

    rxm_div u_div (.aclk, .aresetn, .start(dstart), .a(da), .b(db), .done(ddone), .q(dq));

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic [31:0] ma, mb;
        logic [63:0] p, r;
        begin
            ma = a[31] ? 32'(-a) : 32'(a);
            mb = b[31] ? 32'(-b) : 32'(b);
            p = ma * mb;
            r = (p + 64'd8388608) >> QFRAC;
            return (a[31] ^ b[31]) ? sat32(-$signed({2'd0, r})) : sat32($signed({2'd0, r}));
        end
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        begin
            return sat32(66'(a) - 66'(b));
        end
    endfunction

    function automatic logic [1:0] nx(input logic [1:0] i, input logic [1:0] d);
        logic [2:0] s;
        begin
            s = 3'(i) + 3'(d);
            return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
        end
    endfunction

    // Flat index of a 3x3 entry: 3*r + c.
    function automatic logic [3:0] idx(input logic [1:0] r, input logic [1:0] c);
        begin
            return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
        end
    endfunction

    function automatic logic [1:0] row_of(input logic [3:0] f);
        begin
            return (f >= 4'd6) ? 2'd2 : ((f >= 4'd3) ? 2'd1 : 2'd0);
        end
    endfunction

    function automatic logic [1:0] col_of(input logic [3:0] f, input logic [1:0] r);
        logic [3:0] d;
        begin
            d = f - idx(r, 2'd0);
            return d[1:0];
        end
    endfunction

    // Column step k: 0..3 chroma columns; for each, x/y then z/y.
    logic [1:0]  ci;
    logic [15:0] cx, cy;
    logic [1:0]  ir, ic, er, ec;
    logic [3:0]  fi, ek;
    logic signed [31:0] cof_v, prod_v, madd;
    logic        singular, ov_set;

    always_comb begin
        ci = k_reg[2:1];
        unique case (ci)
            2'd0: begin cx = c_reg.rx; cy = c_reg.ry; end
            2'd1: begin cx = c_reg.gx; cy = c_reg.gy; end
            2'd2: begin cx = c_reg.bx; cy = c_reg.by; end
            default: begin cx = c_reg.wx; cy = c_reg.wy; end
        endcase
        fi = 4'(k_reg);
        ir = row_of(fi);
        ic = col_of(fi, ir);
        ek = (k_reg >= 5'd9) ? 4'(k_reg - 5'd9) : fi;
        er = row_of(ek);
        ec = col_of(ek, er);
        cof_v = qsub(qmul(p_reg[idx(nx(ir, 2'd1), nx(ic, 2'd1))],
                          p_reg[idx(nx(ir, 2'd2), nx(ic, 2'd2))]),
                     qmul(p_reg[idx(nx(ir, 2'd1), nx(ic, 2'd2))],
                          p_reg[idx(nx(ir, 2'd2), nx(ic, 2'd1))]));
        dstart = 1'b0; da = '0; db = '0;
        if (state_reg == S_COL) begin
            dstart = 1'b1;
            db = $signed({8'd0, cy, 8'd0});
            da = k_reg[0] ? $signed(32'({17'd0, 17'h10000} - {17'd0, 1'b0, cx} -
                                       {17'd0, 1'b0, cy}) << 8)
                          : $signed({8'd0, cx, 8'd0});
        end else if (state_reg == S_IDIV) begin
            dstart = 1'b1;
            da = cof_reg[idx(ic, ir)];
            db = det_reg;
        end
        prod_v = qmul(k_reg[4] ? m_reg[{2'b00, k_reg[1:0]}]
                               : inv_reg[idx(k_reg[3:2], k_reg[1:0])],
                      k_reg[4] ? cof_reg[{2'b00, k_reg[1:0]}] : wh_reg[k_reg[1:0]]);
        madd = sat32(66'(det_reg) + 66'(prod_v));
        singular = ($signed(madd) < $signed({1'b0, min_det})) || (madd == 32'sd0);
        ov_set = ((state_reg == S_IDLE) && q_valid && q_ready && q_job.zero_y) ||
                 ((state_reg == S_DET) && (k_reg == 5'd18) && singular) ||
                 ((state_reg == S_EMIT) && (!ov_reg || m_ready));
    end

    // A waiting result that is taken this cycle frees the output register for the next item.
    assign q_ready = (state_reg == S_IDLE) && (!ov_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; ov_reg <= 1'b0; k_reg <= '0; pass_reg <= 1'b0;
        end else begin
            ov_reg <= ov_set || (ov_reg && !m_ready);
            unique case (state_reg)
                S_IDLE: if (q_valid && q_ready) begin
                    c_reg <= q_job.c;
                    k_reg <= '0; pass_reg <= 1'b0;
                    if (q_job.zero_y) begin
                        ow_reg <= 1'b0; orow_reg <= '0; ocol_reg <= '0;
                        oval_reg <= '0; ost_reg <= ST_BAD_P; ol_reg <= 1'b1;
                    end else state_reg <= S_COL;
                end
                S_COL: state_reg <= S_COLW;
                S_COLW: if (ddone) begin
                    if (ci == 2'd3) wh_reg[k_reg[0] ? 2'd2 : 2'd0] <= dq;
                    else begin
                        p_reg[idx(k_reg[0] ? 2'd2 : 2'd0, ci)] <= dq;
                        pp_reg[idx(k_reg[0] ? 2'd2 : 2'd0, ci)] <= dq;
                        p_reg[idx(2'd1, ci)] <= QONE;
                        pp_reg[idx(2'd1, ci)] <= QONE;
                    end
                    wh_reg[1] <= QONE;
                    if (k_reg == 5'd7) begin
                        k_reg <= '0; state_reg <= S_INV;
                    end else begin
                        k_reg <= k_reg + 5'd1; state_reg <= S_COL;
                    end
                end
                S_INV: begin
                    cof_reg[fi] <= cof_v;
                    if (k_reg == 5'd8) begin
                        k_reg <= 5'd16; det_reg <= '0; state_reg <= S_DET;
                        for (int i = 0; i < 3; i++) m_reg[i] <= p_reg[i];
                    end else k_reg <= k_reg + 5'd1;
                end
                S_DET: begin
                    det_reg <= madd;
                    if (k_reg == 5'd18) begin
                        k_reg <= '0;
                        if (singular) begin
                            ow_reg <= 1'b0; orow_reg <= '0;
                            ocol_reg <= '0; oval_reg <= '0; ol_reg <= 1'b1;
                            ost_reg <= pass_reg ? ST_BAD_M : ST_BAD_P;
                            state_reg <= S_IDLE;
                        end else state_reg <= S_IDIV;
                    end else k_reg <= k_reg + 5'd1;
                end
                S_IDIV: state_reg <= S_IDIVW;
                S_IDIVW: if (ddone) begin
                    inv_reg[fi] <= dq;
                    if (k_reg == 5'd8) begin
                        k_reg <= '0;
                        if (pass_reg) begin
                            det_reg <= '0; state_reg <= S_EMIT;
                        end else begin
                            det_reg <= '0; state_reg <= S_WT;
                        end
                    end else begin
                        k_reg <= k_reg + 5'd1; state_reg <= S_IDIV;
                    end
                end
                // k[3:2] row, k[1:0] term of inv(P) * white.
                S_WT: begin
                    if (k_reg[1:0] == 2'd2) begin
                        w_reg[k_reg[3:2]] <= madd; det_reg <= '0;
                        if (k_reg[3:2] == 2'd2) begin
                            k_reg <= '0; state_reg <= S_MM;
                        end else k_reg <= {1'b0, k_reg[3:2] + 2'd1, 2'd0};
                    end else begin
                        det_reg <= madd; k_reg <= k_reg + 5'd1;
                    end
                end
                S_MM: begin
                    p_reg[fi] <= qmul(w_reg[ic], pp_reg[fi]);
                    m_reg[fi] <= qmul(w_reg[ic], pp_reg[fi]);
                    if (k_reg == 5'd8) begin
                        k_reg <= '0; pass_reg <= 1'b1; state_reg <= S_INV;
                    end else k_reg <= k_reg + 5'd1;
                end
                S_EMIT: if (!ov_reg || m_ready) begin
                    ost_reg <= ST_OK;
                    ow_reg <= (k_reg >= 5'd9);
                    orow_reg <= er;
                    ocol_reg <= ec;
                    oval_reg <= (k_reg >= 5'd9) ? inv_reg[ek] : m_reg[ek];
                    ol_reg <= (k_reg == 5'd17);
                    if (k_reg == 5'd17) begin
                        k_reg <= '0; state_reg <= S_IDLE;
                    end else k_reg <= k_reg + 5'd1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = ov_reg; assign m_which = ow_reg; assign m_row = orow_reg;
    assign m_col = ocol_reg; assign m_val = oval_reg; assign m_status = ost_reg;
    assign m_last = ol_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_val)) else $error("out dropped");
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_last) else $error("error not last");
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> state_reg == S_IDLE) else $error("take while busy");
endmodule
`default_nettype wire

// ===== sv/rgb_xyz_matrix_from_primaries.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The shared divider runs 26 quotients per item. An item is taken from the queue only
// once the previous one is finished, and gives 18 results; the queue holds two.
// Error items give one result only: for singular primaries, for a singular XYZ
// matrix, or for zero y.
// Reset (aresetn low, synchronous) empties the queue, drops any result, sets min_det to 16777.
module rgb_xyz_matrix_from_primaries (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_red_x,
    input  wire logic [15:0] s_red_y,
    input  wire logic [15:0] s_green_x,
    input  wire logic [15:0] s_green_y,
    input  wire logic [15:0] s_blue_x,
    input  wire logic [15:0] s_blue_y,
    input  wire logic [15:0] s_white_x,
    input  wire logic [15:0] s_white_y,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_which_matrix,
    output logic [1:0]       m_row_index,
    output logic [1:0]       m_col_index,
    output logic signed [31:0] m_entry_value,
    output logic [1:0]       m_status,
    output logic             m_last_entry
);
    import rxm_pkg::*;

    logic [30:0] min_det_reg;
    chroma_t     in_c;
    job_t        qj;
    logic        qv, qr;

    // The single register lives at address zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) min_det_reg <= MIN_DET_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0) min_det_reg <= pwdata[30:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {1'b0, min_det_reg} : 32'd0;

    assign in_c = '{rx: s_red_x, ry: s_red_y, gx: s_green_x, gy: s_green_y,
                    bx: s_blue_x, by: s_blue_y, wx: s_white_x, wy: s_white_y};

    rxm_front u_front (.aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .in_c(in_c), .q_valid(qv), .q_ready(qr), .q_job(qj));

    rxm_back u_back (.aclk, .aresetn, .min_det(min_det_reg), .q_valid(qv), .q_ready(qr),
        .q_job(qj), .m_valid, .m_ready, .m_which(m_which_matrix), .m_row(m_row_index),
        .m_col(m_col_index), .m_val(m_entry_value), .m_status, .m_last(m_last_entry));
endmodule
`default_nettype wire
